>>> src/binary_max_heap_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary max-heap priority queue
// Concurrent checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// property holds at every edge outside reset
`define BHPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition never occurs outside reset
`define BHPQ_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BHPQ_ASSERT(lbl, clk, rst, prop, msg)
`define BHPQ_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> src/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Types and codes shared by the heap priority queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

   localparam int unsigned FIELD_W = 8;
   localparam int unsigned CNT_W   = 11;
   localparam int unsigned PRIO_W  = 10;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [FIELD_W-1:0] health;
      logic [FIELD_W-1:0] damage;
      logic [FIELD_W-1:0] skill;
   } entry_type;

   typedef struct packed {
      logic               op;
      logic [FIELD_W-1:0] health_in;
      logic [FIELD_W-1:0] damage_in;
      logic [FIELD_W-1:0] skill_in;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] health_out;
      logic [FIELD_W-1:0] damage_out;
      logic [FIELD_W-1:0] skill_out;
      logic [CNT_W-1:0]   entry_count;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_LOAD,
      S_DN_RDL,
      S_DN_CMPL,
      S_DN_CMPR,
      S_DN_MOVE,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

>>> src/bhpq_mem.sv
// ----------------------------------------------------------------------------
// bhpq_mem
// Heap entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_mem
   import bhpq_pkg::*;
#(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data_ff
);

   entry_type heap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= heap_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/bhpq_cmp.sv
// ----------------------------------------------------------------------------
// bhpq_cmp
// Shared priority comparator: a_gt is set when prio(a) > prio(b).
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_cmp
   import bhpq_pkg::*;
(
   input  wire entry_type a,
   input  wire entry_type b,
   output logic           a_gt
);

   logic [PRIO_W-1:0] prio_a;
   logic [PRIO_W-1:0] prio_b;

   // sum of the three fields; /3 would not change the order
   assign prio_a = PRIO_W'(a.health) + PRIO_W'(a.damage) + PRIO_W'(a.skill);
   assign prio_b = PRIO_W'(b.health) + PRIO_W'(b.damage) + PRIO_W'(b.skill);
   assign a_gt   = prio_a > prio_b;

endmodule

`default_nettype wire

>>> src/binary_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Array-based max-heap; push sifts up, pop sifts down, one result per word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_data (op, health/damage/skill)
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_data (entry, count, status)
//
//  req_ready is high only in idle. Push reads and compares each parent on the
//  way up; pop loads the last entry into the root and, per level, reads the left
//  and, if present, the right child, compares and moves. Last-entry pop and
//  refused ops go straight to the done step. Synchronous reset empties the
//  queue; memory is not cleared. A held result stalls only the final step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "binary_max_heap_priority_queue_defines.svh"

module binary_max_heap_priority_queue
   import bhpq_pkg::*;
#(
   parameter int unsigned CAPACITY = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned XW = AW + 2;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [AW-1:0]   pos_ff, pos_in;
   entry_type       cur_ff, cur_in;
   entry_type       best_val_ff, best_val_in;
   logic [AW-1:0]   best_idx_ff, best_idx_in;
   logic            take_ff, take_in;
   logic            is_pop_ff, is_pop_in;
   logic [1:0]      status_ff, status_in;
   entry_type       res_ent_ff, res_ent_in;
   entry_type       top_ff;

   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_waddr, mem_raddr;
   entry_type       mem_wdata, mem_rdata;
   entry_type       cmp_a, cmp_b;
   logic            cmp_gt;

   logic            req_fire, full, empty, out_free;
   logic [AW-1:0]   parent, last_idx;
   logic [XW-1:0]   child_l, child_r, cnt_x;
   logic            l_ok, r_ok;
   entry_type       req_ent, done_ent;

   bhpq_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (mem_waddr),
      .wr_data    (mem_wdata),
      .rd_en      (mem_re),
      .rd_addr    (mem_raddr),
      .rd_data_ff (mem_rdata)
   );

   bhpq_cmp u_cmp (
      .a    (cmp_a),
      .b    (cmp_b),
      .a_gt (cmp_gt)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign parent   = (pos_ff - AW'(1)) >> 1;
   assign last_idx = AW'(count_ff - CW'(1));
   assign child_l  = {1'b0, pos_ff, 1'b1};
   assign child_r  = child_l + XW'(1);
   assign cnt_x    = XW'(count_ff);
   assign l_ok     = child_l < cnt_x;
   assign r_ok     = child_r < cnt_x;
   assign req_ent  = '{health: req_data.health_in, damage: req_data.damage_in,
                       skill: req_data.skill_in};
   assign done_ent = is_pop_ff ? res_ent_ff : top_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.op == OP_PUSH) begin
                  state_in = full ? S_DONE : S_UP_RD;
               end else if (empty || count_ff == CW'(1)) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_DN_LOAD;
               end
            end
         end
         S_UP_RD:   state_in = (pos_ff == '0) ? S_DONE : S_UP_CMP;
         S_UP_CMP:  state_in = cmp_gt ? S_UP_RD : S_DONE;
         S_DN_LOAD: state_in = S_DN_RDL;
         S_DN_RDL:  state_in = l_ok ? S_DN_CMPL : S_DONE;
         S_DN_CMPL: state_in = r_ok ? S_DN_CMPR : S_DN_MOVE;
         S_DN_CMPR: state_in = S_DN_MOVE;
         S_DN_MOVE: state_in = take_ff ? S_DN_RDL : S_DONE;
         S_DONE:    state_in = out_free ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath control and register updates
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      take_in      = take_ff;
      is_pop_in    = is_pop_ff;
      status_in    = status_ff;
      res_ent_in   = res_ent_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = cur_ff;
      mem_re       = 1'b0;
      mem_raddr    = parent;
      cmp_a        = cur_ff;
      cmp_b        = mem_rdata;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               is_pop_in = (req_data.op == OP_POP);
               status_in = STATUS_OK;
               if (req_data.op == OP_PUSH) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     pos_in   = AW'(count_ff);
                     cur_in   = req_ent;
                     count_in = count_ff + CW'(1);
                  end
               end else if (empty) begin
                  status_in  = STATUS_EMPTY;
                  res_ent_in = '0;
               end else begin
                  res_ent_in = top_ff;
                  count_in   = count_ff - CW'(1);
                  pos_in     = '0;
                  // fetch the last entry; it moves to the root
                  mem_re     = 1'b1;
                  mem_raddr  = last_idx;
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we = 1'b1;
            end else begin
               mem_re = 1'b1;
            end
         end
         S_UP_CMP: begin
            mem_we = 1'b1;
            if (cmp_gt) begin
               // parent strictly smaller: move it down into the hole
               mem_wdata = mem_rdata;
               pos_in    = parent;
            end
         end
         S_DN_LOAD: begin
            cur_in = mem_rdata;
         end
         S_DN_RDL: begin
            if (l_ok) begin
               mem_re    = 1'b1;
               mem_raddr = child_l[AW-1:0];
            end else begin
               mem_we = 1'b1;
            end
         end
         S_DN_CMPL: begin
            cmp_a = mem_rdata;
            cmp_b = cur_ff;
            take_in     = cmp_gt;
            best_val_in = cmp_gt ? mem_rdata : cur_ff;
            best_idx_in = child_l[AW-1:0];
            if (r_ok) begin
               mem_re    = 1'b1;
               mem_raddr = child_r[AW-1:0];
            end
         end
         S_DN_CMPR: begin
            // right wins only when strictly greater, so ties keep the left
            cmp_a = mem_rdata;
            cmp_b = best_val_ff;
            if (cmp_gt) begin
               take_in     = 1'b1;
               best_val_in = mem_rdata;
               best_idx_in = child_r[AW-1:0];
            end
         end
         S_DN_MOVE: begin
            mem_we = 1'b1;
            if (take_ff) begin
               mem_wdata = best_val_ff;
               pos_in    = best_idx_ff;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.health_out  = done_ent.health;
               rsp_in.damage_out  = done_ent.damage;
               rsp_in.skill_out   = done_ent.skill;
               rsp_in.entry_count = CNT_W'(count_ff);
               rsp_in.status      = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      take_ff     <= take_in;
      is_pop_ff   <= is_pop_in;
      status_ff   <= status_in;
      res_ent_ff  <= res_ent_in;
      // shadow of the root so the top needs no extra read
      if (mem_we && mem_waddr == '0) begin
         top_ff <= mem_wdata;
      end
   end

   `BHPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `BHPQ_ASSERT(a_full_count, clock, reset, (rsp_valid_ff && rsp_ff.status == STATUS_FULL) |-> (rsp_ff.entry_count == CNT_W'(CAPACITY)), "full refusal with wrong count")
   `BHPQ_ASSERT(a_empty_count, clock, reset, (rsp_valid_ff && rsp_ff.status == STATUS_EMPTY) |-> (rsp_ff.entry_count == '0), "empty refusal with nonzero count")
   `BHPQ_ASSERT_NEVER(a_idle_write, clock, reset, mem_we && (state_ff == S_IDLE || state_ff == S_DONE), "heap write outside a sift")

endmodule

`default_nettype wire

>>> test/tb_binary_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_binary_max_heap_priority_queue
// Drives push and pop words into the heap queue with random gaps on both
// channels, keeps its own heap image to predict each result word, and
// compares every result field by field in order. Covers empty pops, ties,
// filling to capacity with refused pushes, and a long result-side stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bhpq_pkg::*;

class heap_scoreboard;
   entry_type   heap[];
   int unsigned depth;
   int unsigned count;
   rsp_type     expected_rsp[$];
   int unsigned results_checked;
   int unsigned errors;

   function new(int unsigned heap_depth);
      depth = heap_depth;
      heap = new[heap_depth];
      count = 0;
      results_checked = 0;
      errors = 0;
   endfunction

   function logic [PRIO_W-1:0] prio(entry_type e);
      return {2'b00, e.health} + {2'b00, e.damage} + {2'b00, e.skill};
   endfunction

   function int unsigned pending();
      return expected_rsp.size();
   endfunction

   // update the heap image for an accepted word and queue the result it causes
   function void predict_op(req_type r);
      rsp_type     want;
      entry_type   top;
      entry_type   tmp;
      int unsigned pos;
      int unsigned par;
      int unsigned lc;
      int unsigned rc;
      int unsigned best;
      want = '0;
      top = '0;
      if (r.op == OP_PUSH) begin
         if (count >= depth) begin
            top = heap[0];
            want.status = STATUS_FULL;
         end else begin
            heap[count].health = r.health_in;
            heap[count].damage = r.damage_in;
            heap[count].skill  = r.skill_in;
            pos = count;
            count++;
            // sift up only while the parent is strictly smaller
            while (pos > 0) begin
               par = (pos - 1) / 2;
               if (!(prio(heap[par]) < prio(heap[pos]))) break;
               tmp = heap[par];
               heap[par] = heap[pos];
               heap[pos] = tmp;
               pos = par;
            end
            top = heap[0];
            want.status = STATUS_OK;
         end
      end else if (count == 0) begin
         want.status = STATUS_EMPTY;
      end else begin
         top = heap[0];
         count--;
         heap[0] = heap[count];
         pos = 0;
         // sift down; left child wins ties, swap only on strictly greater
         while (pos < count) begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < count && prio(heap[lc]) > prio(heap[best])) best = lc;
            if (rc < count && prio(heap[rc]) > prio(heap[best])) best = rc;
            if (best == pos) break;
            tmp = heap[pos];
            heap[pos] = heap[best];
            heap[best] = tmp;
            pos = best;
         end
         want.status = STATUS_OK;
      end
      want.health_out  = top.health;
      want.damage_out  = top.damage;
      want.skill_out   = top.skill;
      want.entry_count = count[CNT_W-1:0];
      expected_rsp.push_back(want);
   endfunction

   task report(string msg);
      $display("MISMATCH result %0d: %s", results_checked, msg);
      errors++;
   endtask

   task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   task check_result(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         report($sformatf("unexpected word %h", got));
      end else begin
         want = expected_rsp.pop_front();
         compare_field("health_out", 16'(got.health_out), 16'(want.health_out));
         compare_field("damage_out", 16'(got.damage_out), 16'(want.damage_out));
         compare_field("skill_out", 16'(got.skill_out), 16'(want.skill_out));
         compare_field("entry_count", 16'(got.entry_count), 16'(want.entry_count));
         compare_field("status", 16'(got.status), 16'(want.status));
      end
      results_checked++;
   endtask
endclass

module tb_binary_max_heap_priority_queue;

   localparam int unsigned HEAP_DEPTH   = 1024;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned STALL_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES = 100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   heap_scoreboard sb;
   int unsigned    sent_count = 0;
   int unsigned    cycle_count = 0;

   binary_max_heap_priority_queue #(
      .CAPACITY(HEAP_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #4 clock = ~clock;

   // stretches of back-to-back words between random gaps
   function automatic int draw_gap(int unsigned idx);
      if ((idx / 64) % 4 == 1) return 0;
      return $urandom_range(0, 16);
   endfunction

   function automatic req_type make_req(logic op, logic [7:0] h, logic [7:0] d,
                                        logic [7:0] s);
      req_type r;
      r.op        = op;
      r.health_in = h;
      r.damage_in = d;
      r.skill_in  = s;
      return r;
   endfunction

   task automatic send_word(req_type w);
      int gap;
      gap = draw_gap(sent_count);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.predict_op(w);
      sent_count++;
   endtask

   // small field values half the time so priorities tie often
   task automatic send_random(int unsigned pop_pct);
      logic       op;
      logic [7:0] f[3];
      op = ($urandom_range(1, 100) <= pop_pct) ? OP_POP : OP_PUSH;
      for (int i = 0; i < 3; i++)
         f[i] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                     : 8'($urandom_range(0, 255));
      send_word(make_req(op, f[0], f[1], f[2]));
   endtask

   task automatic run_receiver();
      int gap;
      forever begin
         gap = ((sb.results_checked % 700) == 350) ? STALL_CYCLES
                                                   : draw_gap(sb.results_checked);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(rsp_data);
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      sb = new(HEAP_DEPTH);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      fork
         run_receiver();
      join_none

      // pop on empty, pop of the only entry, extremes, equal priorities
      send_word(make_req(OP_POP, 8'd0, 8'd0, 8'd0));
      send_word(make_req(OP_PUSH, 8'd0, 8'd0, 8'd0));
      send_word(make_req(OP_POP, 8'd255, 8'd255, 8'd255));
      send_word(make_req(OP_PUSH, 8'd255, 8'd255, 8'd255));
      send_word(make_req(OP_PUSH, 8'd0, 8'd0, 8'd0));
      send_word(make_req(OP_PUSH, 8'd255, 8'd255, 8'd255));
      send_word(make_req(OP_PUSH, 8'd170, 8'd85, 8'd170));
      send_word(make_req(OP_PUSH, 8'd85, 8'd170, 8'd85));
      send_word(make_req(OP_PUSH, 8'd1, 8'd2, 8'd3));
      send_word(make_req(OP_PUSH, 8'd3, 8'd2, 8'd1));
      send_word(make_req(OP_PUSH, 8'd2, 8'd2, 8'd2));
      send_word(make_req(OP_PUSH, 8'd255, 8'd0, 8'd0));
      send_word(make_req(OP_PUSH, 8'd0, 8'd255, 8'd0));
      send_word(make_req(OP_PUSH, 8'd0, 8'd0, 8'd255));
      repeat (12) send_word(make_req(OP_POP, 8'hA5, 8'h5A, 8'hFF));

      // mixed traffic around low occupancy
      repeat (300) send_random(45);

      // fill to capacity, then refused pushes around one pop
      while (sb.count < HEAP_DEPTH) send_random(3);
      repeat (4) send_random(0);
      send_random(100);
      repeat (3) send_random(0);

      // drain-biased traffic from full
      repeat (360) send_random(80);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
